@@ rtl/hltf_pkg.sv @@
// Shared types and constants for the header line tag filter.
`default_nettype none

package hltf_pkg;

  localparam int MAX_TAG_DEF      = 8;
  localparam int FILTER_SLOTS_DEF = 6;
  localparam int FILTER_REGS      = 6;
  localparam int FILTER_W         = 64;
  localparam int CFG_INDEX_W      = 3;

  // configuration register indexes (filters occupy 0 .. FILTER_REGS-1)
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_COUNT = 3'd6;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NL    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_AT    = 8'h40;

  typedef logic [FILTER_REGS-1:0][FILTER_W-1:0] filter_bank_t;

  // what one input word asks the emitter to send, in this order:
  // '@' plus buffered tag, one extra byte, the terminator
  typedef struct packed {
    logic flush;
    logic has_byte;
    logic has_term;
  } burst_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/hltf_parse.sv @@
// Line parser: parse state, tag buffer, filter match and burst decode.
`default_nettype none

module hltf_parse #(
  parameter int MAX_TAG      = hltf_pkg::MAX_TAG_DEF,
  parameter int FILTER_SLOTS = hltf_pkg::FILTER_SLOTS_DEF,
  localparam int LW          = $clog2(MAX_TAG + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_fire,
  input  wire logic [7:0]             in_byte,
  input  wire hltf_pkg::filter_bank_t filters,
  input  wire logic [2:0]             filter_count,
  output hltf_pkg::burst_ctrl_t       ctrl,
  output logic [7:0]                  xbyte,
  output logic [8*MAX_TAG-1:0]        tag,
  output logic [LW-1:0]               tag_len
);
  import hltf_pkg::*;

  typedef enum logic [4:0] {
    MODE_FIRST = 5'b00001,
    MODE_SKIP  = 5'b00010,
    MODE_DROP  = 5'b00100,
    MODE_TAG   = 5'b01000,
    MODE_COPY  = 5'b10000
  } mode_t;

  mode_t               mode_r, mode_nxt;
  logic [8*MAX_TAG-1:0] tag_r, tag_nxt;
  logic [LW-1:0]        len_r, len_nxt;

  logic is_nul, is_nl, is_tab, is_at, is_sp, tag_end, do_ls;
  logic [FILTER_REGS-1:0] hit;
  logic match;

  assign is_nul  = (in_byte == CHAR_NUL);
  assign is_nl   = (in_byte == CHAR_NL);
  assign is_tab  = (in_byte == CHAR_TAB);
  assign is_at   = (in_byte == CHAR_AT);
  assign is_sp   = (in_byte == CHAR_SPACE) || ((in_byte >= CHAR_TAB) && (in_byte <= CHAR_CR));
  assign tag_end = is_nul || is_nl || is_tab;

  // filter compare against the buffered tag; length = bytes before first zero
  always_comb begin
    logic [3:0] flen;
    logic       same;
    for (int i = 0; i < FILTER_REGS; i++) begin
      flen = 4'd8;
      for (int j = 7; j >= 0; j--) begin
        if (filters[i][8*j +: 8] == CHAR_NUL) flen = 4'(j);
      end
      same = (flen == 4'(len_r));
      for (int j = 0; j < MAX_TAG; j++) begin
        if (((LW'(j) < len_r) ? filters[i][8*j +: 8] : CHAR_NUL) != tag_r[8*j +: 8]) begin
          same = 1'b0;
        end
      end
      hit[i] = same && (i < FILTER_SLOTS) && (filter_count > 3'(i));
    end
  end

  assign match = |hit;

  always_comb begin
    mode_nxt = mode_r;
    tag_nxt  = tag_r;
    len_nxt  = len_r;
    ctrl     = '0;
    xbyte    = in_byte;
    do_ls    = 1'b0;
    case (mode_r)
      MODE_SKIP: begin
        do_ls = is_nul || !is_sp;
      end
      MODE_DROP: begin
        if (is_nul) begin
          ctrl.has_term = 1'b1;
          mode_nxt      = MODE_FIRST;
        end else if (is_nl) begin
          mode_nxt = MODE_SKIP;
        end
      end
      MODE_TAG: begin
        if (tag_end) begin
          tag_nxt = '0;
          len_nxt = '0;
          if (match) begin
            if (is_nul) begin
              ctrl.has_term = 1'b1;
              mode_nxt      = MODE_FIRST;
            end else begin
              mode_nxt = is_nl ? MODE_SKIP : MODE_DROP;
            end
          end else begin
            ctrl.flush    = 1'b1;
            ctrl.has_byte = 1'b1;
            if (is_tab) begin
              mode_nxt = MODE_COPY;
            end else begin
              xbyte         = CHAR_NL;
              ctrl.has_term = is_nul;
              mode_nxt      = is_nul ? MODE_FIRST : MODE_SKIP;
            end
          end
        end else if (len_r < LW'(MAX_TAG)) begin
          for (int j = 0; j < MAX_TAG; j++) begin
            if (len_r == LW'(j)) tag_nxt[8*j +: 8] = in_byte;
          end
          len_nxt = len_r + LW'(1);
        end else begin
          // tag too long to match anything: flush and keep the line
          ctrl.flush    = 1'b1;
          ctrl.has_byte = 1'b1;
          tag_nxt       = '0;
          len_nxt       = '0;
          mode_nxt      = MODE_COPY;
        end
      end
      MODE_COPY: begin
        ctrl.has_byte = 1'b1;
        if (is_nl || is_nul) begin
          xbyte         = CHAR_NL;
          ctrl.has_term = is_nul;
          mode_nxt      = is_nul ? MODE_FIRST : MODE_SKIP;
        end
      end
      default: begin
        do_ls = 1'b1;
      end
    endcase

    if (do_ls) begin
      if (is_nul) begin
        ctrl.has_term = 1'b1;
        mode_nxt      = MODE_FIRST;
        tag_nxt       = '0;
        len_nxt       = '0;
      end else if (is_at) begin
        tag_nxt  = '0;
        len_nxt  = '0;
        mode_nxt = MODE_TAG;
      end else if (is_nl) begin
        mode_nxt = MODE_SKIP;
      end else begin
        mode_nxt = MODE_DROP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FIRST;
      tag_r  <= '0;
      len_r  <= '0;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      tag_r  <= tag_nxt;
      len_r  <= len_nxt;
    end
  end

  assign tag     = tag_r;
  assign tag_len = len_r;

endmodule

`default_nettype wire

@@ rtl/hltf_emit.sv @@
// Result queue: packs one word's burst into slots and sends them one per cycle while out_ready is high.
`default_nettype none

module hltf_emit #(
  parameter int  MAX_TAG = hltf_pkg::MAX_TAG_DEF,
  localparam int LW      = $clog2(MAX_TAG + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_fire,
  output logic                       ready,
  input  wire hltf_pkg::burst_ctrl_t ctrl,
  input  wire logic [7:0]            xbyte,
  input  wire logic [8*MAX_TAG-1:0]  tag,
  input  wire logic [LW-1:0]         tag_len,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_byte,
  output logic                       out_text_end,
  output logic                       out_run_last
);
  import hltf_pkg::*;

  // '@' + full tag + one extra byte + terminator
  localparam int BURST = MAX_TAG + 3;
  // one more entry keeps a word still waiting on out_ready when a burst loads
  localparam int DEPTH = BURST + 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [7:0]  byte_q_r [DEPTH];
  logic        end_q_r  [DEPTH];
  logic        last_q_r [DEPTH];
  logic [CW-1:0] cnt_r;

  logic [7:0]  slot_byte [BURST];
  logic        slot_end  [BURST];
  logic        slot_last [BURST];
  logic [CW-1:0] base, total;
  logic [8*(MAX_TAG+1)-1:0] flush_vec;
  logic take;
  logic keep;

  assign flush_vec = {tag, CHAR_AT};
  assign base  = ctrl.flush ? (CW'(tag_len) + CW'(1)) : '0;
  assign total = base + CW'(ctrl.has_byte) + CW'(ctrl.has_term);

  for (genvar i = 0; i < BURST; i++) begin : g_slot
    logic in_flush;
    if (i < MAX_TAG + 1) begin : g_fl
      assign in_flush = ctrl.flush && (CW'(i) <= CW'(tag_len));
    end else begin : g_nofl
      assign in_flush = 1'b0;
    end

    always_comb begin
      slot_byte[i] = CHAR_NUL;
      slot_end[i]  = 1'b0;
      if (in_flush) begin
        slot_byte[i] = flush_vec[8*(i % (MAX_TAG + 1)) +: 8];
      end else if (ctrl.has_byte && (CW'(i) == base)) begin
        slot_byte[i] = xbyte;
      end else if (ctrl.has_term && (CW'(i) == base + CW'(ctrl.has_byte))) begin
        slot_end[i] = 1'b1;
      end
      slot_last[i] = (CW'(i + 1) == total);
    end
  end

  assign out_valid = (cnt_r != '0);
  assign take      = out_valid && out_ready;
  // a new burst loads behind at most one queued word
  assign ready     = (cnt_r <= CW'(1));
  // the queued word stays at the head and the burst goes in behind it
  assign keep      = (cnt_r == CW'(1)) && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_fire) begin
      cnt_r <= total + CW'(keep);
    end else if (take) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (keep) begin
        for (int i = 0; i < BURST; i++) begin
          byte_q_r[i+1] <= slot_byte[i];
          end_q_r[i+1]  <= slot_end[i];
          last_q_r[i+1] <= slot_last[i];
        end
      end else begin
        for (int i = 0; i < BURST; i++) begin
          byte_q_r[i] <= slot_byte[i];
          end_q_r[i]  <= slot_end[i];
          last_q_r[i] <= slot_last[i];
        end
      end
    end else if (take) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        byte_q_r[i] <= byte_q_r[i+1];
        end_q_r[i]  <= end_q_r[i+1];
        last_q_r[i] <= last_q_r[i+1];
      end
    end
  end

  assign out_byte     = byte_q_r[0];
  assign out_text_end = end_q_r[0];
  assign out_run_last = last_q_r[0];

endmodule

`default_nettype wire

@@ rtl/header_line_tag_filter.sv @@
// Top level of the header line tag filter: config registers, parser and result queue.
// Text enters one byte per word; a zero byte ends the text and is echoed as a
// terminator word (out_text_end high). Lines starting with '@' are kept unless
// the tag (bytes after '@' up to tab, newline or end) equals an enabled filter;
// other lines are dropped and whitespace after each newline is skipped. Words
// that yield at most one result stream at one byte per clock while out_ready is
// high, with the input taken while the previous result still waits. A word that
// yields n results (tag flush: up to MAX_TAG+3) holds in_ready low until the result
// queue is down to one word, as the queue drains one word per cycle with out_ready
// high. Words that yield nothing (dropped or buffered bytes) are still taken.
// in_ready never depends on out_ready in the same cycle. Filters and filter_count
// are written through cfg_we/cfg_index/cfg_wdata; the user writes them only while
// the block is idle, which the block itself does not enforce. Index 6 is the
// filter count, indexes 0..5 the filter tags.
`default_nettype none

module header_line_tag_filter #(
  parameter int MAX_TAG      = hltf_pkg::MAX_TAG_DEF,
  parameter int FILTER_SLOTS = hltf_pkg::FILTER_SLOTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input text words
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       in_byte,
  // filtered result words
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [7:0]                            out_byte,
  output logic                                  out_text_end,
  output logic                                  out_run_last,
  // configuration writes
  input  wire logic                             cfg_we,
  input  wire logic [hltf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [hltf_pkg::FILTER_W-1:0]    cfg_wdata
);
  import hltf_pkg::*;

  localparam int LW = $clog2(MAX_TAG + 1);

  filter_bank_t filter_r;
  logic [2:0]   count_r;

  burst_ctrl_t          ctrl;
  logic [7:0]           xbyte;
  logic [8*MAX_TAG-1:0] tag;
  logic [LW-1:0]        tag_len;
  logic                 in_fire;

  // config registers; indexes past the count register are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r <= '0;
      count_r  <= '0;
    end else if (cfg_we) begin
      for (int i = 0; i < FILTER_REGS; i++) begin
        if (cfg_index == CFG_INDEX_W'(i)) filter_r[i] <= cfg_wdata;
      end
      if (cfg_index == CFG_IDX_COUNT) count_r <= cfg_wdata[2:0];
    end
  end

  assign in_fire = in_valid && in_ready;

  hltf_parse #(
    .MAX_TAG      (MAX_TAG),
    .FILTER_SLOTS (FILTER_SLOTS)
  ) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_byte      (in_byte),
    .filters      (filter_r),
    .filter_count (count_r),
    .ctrl         (ctrl),
    .xbyte        (xbyte),
    .tag          (tag),
    .tag_len      (tag_len)
  );

  hltf_emit #(
    .MAX_TAG (MAX_TAG)
  ) u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .ready        (in_ready),
    .ctrl         (ctrl),
    .xbyte        (xbyte),
    .tag          (tag),
    .tag_len      (tag_len),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_text_end (out_text_end),
    .out_run_last (out_run_last)
  );

endmodule

`default_nettype wire
